// ----- rtl/jdqt_pkg.sv -----
// ----------------------------------------------------------------------------
// jdqt_pkg
// Types and constants for the dqt lsb extractor: markers, phases, bit top, length header.
// ----------------------------------------------------------------------------
package jdqt_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [2:0] t_phase;

    localparam t_byte MARK_PREFIX = 8'hFF;
    localparam t_byte MARK_DQT    = 8'hDB;

    localparam t_phase PH_HUNT    = 3'd0;
    localparam t_phase PH_PREFIX  = 3'd1;
    localparam t_phase PH_LEN_HI  = 3'd2;
    localparam t_phase PH_LEN_LO  = 3'd3;
    localparam t_phase PH_PAYLOAD = 3'd4;
    localparam t_phase PH_DONE    = 3'd5;

    localparam logic [2:0]  BIT_TOP    = 3'd7;
    localparam logic [15:0] LEN_HEADER = 16'd2;

endpackage

// ----- rtl/jpeg_dqt_lsb_extractor_core.sv -----
// ----------------------------------------------------------------------------
// jpeg_dqt_lsb_extractor_core
// Scans a jpeg byte stream for the first dqt segment and rebuilds characters
// from the lsbs of its quantization values.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle, sustained: each byte drives a single
// update of the phase, length, table and bit counters, and a finished
// character lands in an output register that decouples the two channels, so
// a new byte is accepted whenever that register is empty or being drained in
// the same cycle. The block hunts for 0xFF 0xDB, reads the big-endian segment
// length, skips the id byte at the start of each table of TABLE_ENTRIES
// values, packs value lsbs msb first and emits every eighth bit as a
// character. A trailing partial character is dropped; after the segment all
// bytes are consumed and ignored until reset.
module jpeg_dqt_lsb_extractor_core #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_file_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_hidden_char
);

    localparam int TP_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [TP_W-1:0] TP_LAST = TP_W'(TABLE_ENTRIES);
    localparam logic [TP_W-1:0] TP_ONE  = TP_W'(1);

    jdqt_pkg::t_phase r_phase, n_phase;
    logic [15:0]      r_seg_rem, n_seg_rem;
    logic [TP_W-1:0]  r_tab_pos, n_tab_pos;
    logic [2:0]       r_bit_idx, n_bit_idx;
    logic [7:0]       r_char, n_char;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_char, n_out_char;

    logic             in_take;
    logic             emit;
    logic [15:0]      len;
    logic [15:0]      seg_dec;
    logic [7:0]       char_or;

    assign o_ready       = !r_out_valid || i_ready;
    assign in_take       = i_valid && o_ready;
    assign o_valid       = r_out_valid;
    assign o_hidden_char = r_out_char;

    assign len     = {r_seg_rem[15:8], i_file_byte};
    assign seg_dec = r_seg_rem - 16'd1;
    assign char_or = r_char | (8'(i_file_byte[0]) << r_bit_idx);

    always_comb begin
        n_phase   = r_phase;
        n_seg_rem = r_seg_rem;
        n_tab_pos = r_tab_pos;
        n_bit_idx = r_bit_idx;
        n_char    = r_char;
        emit      = 1'b0;
        if (in_take) begin
            case (r_phase)
                jdqt_pkg::PH_HUNT: begin
                    if (i_file_byte == jdqt_pkg::MARK_PREFIX) begin
                        n_phase = jdqt_pkg::PH_PREFIX;
                    end
                end
                jdqt_pkg::PH_PREFIX: begin
                    n_phase = (i_file_byte == jdqt_pkg::MARK_DQT) ?
                              jdqt_pkg::PH_LEN_HI : jdqt_pkg::PH_HUNT;
                end
                jdqt_pkg::PH_LEN_HI: begin
                    n_seg_rem = {i_file_byte, 8'h00};
                    n_phase   = jdqt_pkg::PH_LEN_LO;
                end
                jdqt_pkg::PH_LEN_LO: begin
                    if (len <= jdqt_pkg::LEN_HEADER) begin
                        n_seg_rem = '0;
                        n_phase   = jdqt_pkg::PH_DONE;
                    end else begin
                        n_seg_rem = len - jdqt_pkg::LEN_HEADER;
                        n_phase   = jdqt_pkg::PH_PAYLOAD;
                    end
                end
                jdqt_pkg::PH_PAYLOAD: begin
                    if (r_tab_pos == '0) begin
                        // table id byte, skipped
                        n_tab_pos = TP_ONE;
                    end else begin
                        if (r_bit_idx == 3'd0) begin
                            emit      = 1'b1;
                            n_char    = '0;
                            n_bit_idx = jdqt_pkg::BIT_TOP;
                        end else begin
                            n_char    = char_or;
                            n_bit_idx = r_bit_idx - 3'd1;
                        end
                        n_tab_pos = (r_tab_pos >= TP_LAST) ? '0 : r_tab_pos + TP_ONE;
                    end
                    n_seg_rem = seg_dec;
                    if (seg_dec == 16'd0) begin
                        n_phase = jdqt_pkg::PH_DONE;
                    end
                end
                jdqt_pkg::PH_DONE: begin
                    n_phase = jdqt_pkg::PH_DONE;
                end
                default: begin
                    n_phase = jdqt_pkg::PH_DONE;
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        n_out_char  = r_out_char;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_char  = char_or;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= jdqt_pkg::PH_HUNT;
            r_seg_rem   <= '0;
            r_tab_pos   <= '0;
            r_bit_idx   <= jdqt_pkg::BIT_TOP;
            r_char      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_seg_rem   <= n_seg_rem;
            r_tab_pos   <= n_tab_pos;
            r_bit_idx   <= n_bit_idx;
            r_char      <= n_char;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_char <= n_out_char;
    end

endmodule
